/* design/voxel_euclidean_distance_transform_assert.svh */
// ============================================================================
// Assertion macros for the voxel distance transform
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ============================================================================
`ifndef VOXEL_EUCLIDEAN_DISTANCE_TRANSFORM_ASSERT_SVH
`define VOXEL_EUCLIDEAN_DISTANCE_TRANSFORM_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define VEDT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define VEDT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define VEDT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define VEDT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

/* design/vedt_pkg.sv */
// ============================================================================
// vedt_pkg
// Shared types and constants for the voxel distance transform.
// ============================================================================
`timescale 1ns / 1ps

package vedt_pkg;

  // Width of a stored distance and the value seeded into free interior cells.
  localparam int DIST_W   = 12;
  localparam int SEED_FAR = 4095;

  // Reset value of the dimension registers.
  localparam logic [5:0] DIM_RESET = 6'd32;

  // Input item kinds.
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_RUN   = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DIM_X = 2'd0;
  localparam logic [1:0] CFG_DIM_Y = 2'd1;
  localparam logic [1:0] CFG_DIM_Z = 2'd2;

  // Axis codes for the line sweeps.
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ACCEPT,
    OP_WRITE,
    OP_READ,
    OP_POST,
    OP_SEED_RD,
    OP_SEED_WR,
    OP_LOAD_RD,
    OP_LOAD_WR,
    OP_B_INIT,
    OP_B_RDA,
    OP_B_RDF,
    OP_B_CALC,
    OP_B_CMP,
    OP_E_INIT,
    OP_E_RDC,
    OP_E_CMP,
    OP_E_RDF,
    OP_E_WR
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic q_last;
    logic j_last;
    logic i_last;
    logic axis_last;
    logic n_one;
    logic pop;
    logic adv;
    logic out_free;
  } status_t;

endpackage

/* design/voxel_euclidean_distance_transform.sv */
// ============================================================================
// voxel_euclidean_distance_transform
// 3-D squared Euclidean distance transform over a voxel free map.
// ============================================================================
//
//  Channel   Handshake             Payload
//  in        in_valid/in_ready     kind, cell_x, cell_y, cell_z, free_mark
//  out       out_valid/out_ready   finished, in_grid, squared_distance
//  cfg       cfg_valid/cfg_ready   cfg_index, cfg_data
//
// After reset the block clears all MAX_DIM**3 cells of both voxel memories
// (32768 by default), one cell per cycle, before it takes an item.
// A write passes through a write state; a read is followed by a post that
// may wait on the result register. A run seeds each cell by a read and a
// write, then per axis loads each line, pushes and pops parabolas, evaluates
// each cell; all of this walks one port of the distance memory in order.
// One item is in flight at a time; a finished result waits in the output
// register until transferred, and configuration writes are always taken.
`timescale 1ns / 1ps

module voxel_euclidean_distance_transform #(
  parameter int MAX_DIM = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  kind,
  input  logic [4:0]                  cell_x,
  input  logic [4:0]                  cell_y,
  input  logic [4:0]                  cell_z,
  input  logic                        free_mark,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        finished,
  output logic                        in_grid,
  output logic [vedt_pkg::DIST_W-1:0] squared_distance,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [5:0]                  cfg_data
);
  import vedt_pkg::*;

  cmd_t    cmd;
  status_t stat;

  // Configuration registers accept a transfer in any cycle.
  assign cfg_ready = 1'b1;

  vedt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  vedt_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .kind             (kind),
    .cell_x           (cell_x),
    .cell_y           (cell_y),
    .cell_z           (cell_z),
    .free_mark        (free_mark),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .finished         (finished),
    .in_grid          (in_grid),
    .squared_distance (squared_distance)
  );

endmodule

/* design/vedt_ctrl.sv */
// ============================================================================
// vedt_ctrl
// Sequencer for memory clear, item handling, seeding and the line sweeps.
// ============================================================================
`timescale 1ns / 1ps

module vedt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        kind,
  input  vedt_pkg::status_t stat,
  output logic              in_ready,
  output vedt_pkg::cmd_t    cmd
);
  import vedt_pkg::*;

  typedef enum logic [18:0] {
    S_CLEAR   = 19'd1,
    S_IDLE    = 19'd2,
    S_WRITE   = 19'd4,
    S_READ    = 19'd8,
    S_POST    = 19'd16,
    S_SEED_RD = 19'd32,
    S_SEED_WR = 19'd64,
    S_LOAD_RD = 19'd128,
    S_LOAD_WR = 19'd256,
    S_B_INIT  = 19'd512,
    S_B_RDA   = 19'd1024,
    S_B_RDF   = 19'd2048,
    S_B_CALC  = 19'd4096,
    S_B_CMP   = 19'd8192,
    S_E_INIT  = 19'd16384,
    S_E_RDC   = 19'd32768,
    S_E_CMP   = 19'd65536,
    S_E_RDF   = 19'd131072,
    S_E_WR    = 19'd262144
  } state_t;

  state_t state, state_next;

  // State register; reset starts the memory clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // Next state and the datapath operation for this cycle.
  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_ACCEPT;
          case (kind)
            KIND_WRITE: state_next = S_WRITE;
            KIND_RUN:   state_next = S_SEED_RD;
            KIND_READ:  state_next = S_READ;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_WRITE: begin
        cmd.op     = OP_WRITE;
        state_next = S_IDLE;
      end
      S_READ: begin
        cmd.op     = OP_READ;
        state_next = S_POST;
      end
      S_POST: begin
        if (stat.out_free) begin
          cmd.op     = OP_POST;
          state_next = S_IDLE;
        end
      end
      S_SEED_RD: begin
        cmd.op     = OP_SEED_RD;
        state_next = S_SEED_WR;
      end
      S_SEED_WR: begin
        cmd.op = OP_SEED_WR;
        if (stat.q_last && stat.j_last && stat.i_last) state_next = S_LOAD_RD;
        else state_next = S_SEED_RD;
      end
      S_LOAD_RD: begin
        cmd.op     = OP_LOAD_RD;
        state_next = S_LOAD_WR;
      end
      S_LOAD_WR: begin
        cmd.op     = OP_LOAD_WR;
        state_next = stat.q_last ? S_B_INIT : S_LOAD_RD;
      end
      S_B_INIT: begin
        cmd.op     = OP_B_INIT;
        state_next = stat.n_one ? S_E_INIT : S_B_RDA;
      end
      S_B_RDA: begin
        cmd.op     = OP_B_RDA;
        state_next = S_B_RDF;
      end
      S_B_RDF: begin
        cmd.op     = OP_B_RDF;
        state_next = S_B_CALC;
      end
      S_B_CALC: begin
        cmd.op     = OP_B_CALC;
        state_next = S_B_CMP;
      end
      S_B_CMP: begin
        cmd.op = OP_B_CMP;
        if (!stat.pop && stat.q_last) state_next = S_E_INIT;
        else state_next = S_B_RDA;
      end
      S_E_INIT: begin
        cmd.op     = OP_E_INIT;
        state_next = S_E_RDC;
      end
      S_E_RDC: begin
        cmd.op     = OP_E_RDC;
        state_next = S_E_CMP;
      end
      S_E_CMP: begin
        cmd.op     = OP_E_CMP;
        state_next = stat.adv ? S_E_RDC : S_E_RDF;
      end
      S_E_RDF: begin
        cmd.op     = OP_E_RDF;
        state_next = S_E_WR;
      end
      S_E_WR: begin
        cmd.op = OP_E_WR;
        if (!stat.q_last) state_next = S_E_RDC;
        else if (stat.j_last && stat.i_last && stat.axis_last) state_next = S_POST;
        else state_next = S_LOAD_RD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* design/vedt_datapath.sv */
// ============================================================================
// vedt_datapath
// Voxel memories, line scratch stores, envelope arithmetic and result register.
// ============================================================================
`timescale 1ns / 1ps
`include "voxel_euclidean_distance_transform_assert.svh"

module vedt_datapath #(
  parameter int MAX_DIM = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  vedt_pkg::cmd_t                cmd,
  output vedt_pkg::status_t             stat,
  input  logic [1:0]                    kind,
  input  logic [4:0]                    cell_x,
  input  logic [4:0]                    cell_y,
  input  logic [4:0]                    cell_z,
  input  logic                          free_mark,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [5:0]                    cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          finished,
  output logic                          in_grid,
  output logic [vedt_pkg::DIST_W-1:0]   squared_distance
);
  import vedt_pkg::*;

  localparam int CW    = $clog2(MAX_DIM);
  localparam int DW    = ($clog2(MAX_DIM + 1) > 6) ? $clog2(MAX_DIM + 1) : 6;
  localparam int CELLS = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(CELLS);
  localparam int NW    = $clog2(SEED_FAR + 1 + (MAX_DIM - 1) * (MAX_DIM - 1)) + 1;
  localparam int DENW  = $clog2(2 * MAX_DIM);
  localparam int PW    = NW + DENW + 1;
  localparam int SW    = 2 * (DW + 1);
  localparam int RW    = SW + 1;

  // Configuration and item registers.
  logic [5:0]        dim_x, dim_y, dim_z;
  logic [DW-1:0]     du_x, du_y, du_z;
  logic [1:0]        item_kind;
  logic [4:0]        item_x, item_y, item_z;
  logic              item_mark;
  logic              item_inside;
  logic [AW-1:0]     item_addr;

  // Sweep counters.
  logic [AW-1:0]     clr;
  logic [1:0]        axis;
  logic [DW-1:0]     i, j, q;
  logic [CW-1:0]     h, top;
  logic [DW-1:0]     cx, cy, cz;
  logic [DW-1:0]     n, ni, nj;
  logic [AW-1:0]     cur_addr;
  logic              q_last, j_last, i_last;
  logic [DW-1:0]     i_adv, j_adv;
  logic [1:0]        axis_adv;

  // Envelope arithmetic.
  logic signed [NW-1:0] num;
  logic [DENW-1:0]      den;
  logic signed [PW-1:0] prod_a, prod_b, prod_c;
  logic                 pop, adv;
  logic signed [DW:0]   sd;
  logic [SW-1:0]        sq;
  logic [RW-1:0]        r;
  logic [DIST_W-1:0]    eval_val, seed_val;
  logic                 seed_edge;

  // Memories and their read registers.
  logic [DIST_W-1:0]    field_mem [CELLS];
  logic [DIST_W-1:0]    field_rd;
  logic                 free_mem [CELLS];
  logic                 free_rd;
  logic [DIST_W-1:0]    lv_mem [MAX_DIM];
  logic [DIST_W-1:0]    lv_rd_q, lv_rd_v;
  logic [CW-1:0]        apex_mem [MAX_DIM];
  logic [CW-1:0]        apex_rd;
  logic [CW-1:0]        apex_waddr;
  logic [CW-1:0]        apex_wdata;
  logic signed [NW-1:0] cnum_mem [MAX_DIM];
  logic signed [NW-1:0] cnum_rd;
  logic [DENW-1:0]      cden_mem [MAX_DIM];
  logic [DENW-1:0]      cden_rd;
  logic [CW-1:0]        cut_raddr;
  logic                 field_we;
  logic [AW-1:0]        field_waddr;
  logic [DIST_W-1:0]    field_wdata;

  // Dimensions in use: zero counts as one, large values clamp to the grid.
  always_comb begin
    du_x = (dim_x == '0) ? DW'(1) : ((DW'(dim_x) > DW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(dim_x));
    du_y = (dim_y == '0) ? DW'(1) : ((DW'(dim_y) > DW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(dim_y));
    du_z = (dim_z == '0) ? DW'(1) : ((DW'(dim_z) > DW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(dim_z));
  end

  assign item_inside = (DW'(item_x) < du_x) && (DW'(item_y) < du_y) && (DW'(item_z) < du_z);
  assign item_addr   = AW'(item_x) * AW'(MAX_DIM * MAX_DIM) + AW'(item_y) * AW'(MAX_DIM)
                     + AW'(item_z);

  // Map line counters onto grid coordinates for the current axis.
  always_comb begin
    case (axis)
      AXIS_X: begin
        cx = q; cy = i; cz = j;
        n = du_x; ni = du_y; nj = du_z;
      end
      AXIS_Y: begin
        cy = q; cz = i; cx = j;
        n = du_y; ni = du_z; nj = du_x;
      end
      default: begin
        cz = q; cx = i; cy = j;
        n = du_z; ni = du_x; nj = du_y;
      end
    endcase
  end

  assign cur_addr = AW'(cx) * AW'(MAX_DIM * MAX_DIM) + AW'(cy) * AW'(MAX_DIM) + AW'(cz);
  assign q_last   = (q == n - DW'(1));
  assign j_last   = (j == nj - DW'(1));
  assign i_last   = (i == ni - DW'(1));

  // Advance to the next line once the current one is finished.
  always_comb begin
    j_adv    = j + DW'(1);
    i_adv    = i;
    axis_adv = axis;
    if (j_last) begin
      j_adv = '0;
      i_adv = i + DW'(1);
      if (i_last) begin
        i_adv    = '0;
        axis_adv = (axis == AXIS_Z) ? AXIS_X : axis + 2'd1;
      end
    end
  end

  // Seed value: blocked and boundary cells start at zero.
  assign seed_edge = (cx == '0) || (cy == '0) || (cz == '0) ||
                     (cx == du_x - DW'(1)) || (cy == du_y - DW'(1)) || (cz == du_z - DW'(1));
  assign seed_val  = (free_rd && !seed_edge) ? DIST_W'(SEED_FAR) : '0;

  // Cut point comparisons by cross multiplication.
  assign prod_a = PW'(num) * PW'($signed({1'b0, cden_rd}));
  assign prod_b = PW'(cnum_rd) * PW'($signed({1'b0, den}));
  assign prod_c = PW'($signed({1'b0, q})) * PW'($signed({1'b0, cden_rd}));
  assign pop    = (h != '0) && (prod_a <= prod_b);
  assign adv    = (h < top) && (PW'(cnum_rd) < prod_c);

  // Lower envelope value at q, saturated.
  assign sd       = $signed({1'b0, q}) - $signed({1'b0, DW'(apex_rd)});
  assign sq       = $unsigned(SW'(sd) * SW'(sd));
  assign r        = RW'(sq) + RW'(lv_rd_v);
  assign eval_val = (r > RW'(SEED_FAR)) ? DIST_W'(SEED_FAR) : r[DIST_W-1:0];

  always_comb begin
    stat.clear_last = (clr == AW'(CELLS - 1));
    stat.q_last     = q_last;
    stat.j_last     = j_last;
    stat.i_last     = i_last;
    stat.axis_last  = (axis == AXIS_Z);
    stat.n_one      = (n == DW'(1));
    stat.pop        = pop;
    stat.adv        = adv;
    stat.out_free   = !out_valid || out_ready;
  end

  // Control registers: configuration, clear pointer, result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      dim_x     <= DIM_RESET;
      dim_y     <= DIM_RESET;
      dim_z     <= DIM_RESET;
      clr       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DIM_X: dim_x <= cfg_data;
          CFG_DIM_Y: dim_y <= cfg_data;
          CFG_DIM_Z: dim_z <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.op == OP_CLEAR) clr <= clr + AW'(1);
      if (cmd.op == OP_POST) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_POST) begin
      finished         <= (item_kind == KIND_RUN);
      in_grid          <= (item_kind == KIND_READ) && item_inside;
      squared_distance <= ((item_kind == KIND_READ) && item_inside) ? field_rd : '0;
    end
  end

  // Item capture, counters and envelope registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: begin
        item_kind <= kind;
        item_x    <= cell_x;
        item_y    <= cell_y;
        item_z    <= cell_z;
        item_mark <= free_mark;
        axis      <= AXIS_Z;
        i         <= '0;
        j         <= '0;
        q         <= '0;
      end
      OP_SEED_WR, OP_E_WR: begin
        if (q_last) begin
          q    <= '0;
          j    <= j_adv;
          i    <= i_adv;
          axis <= axis_adv;
        end else begin
          q <= q + DW'(1);
        end
      end
      OP_LOAD_WR: begin
        q <= q_last ? '0 : q + DW'(1);
      end
      OP_B_INIT: begin
        h   <= '0;
        top <= '0;
        q   <= DW'(1);
      end
      OP_B_CALC: begin
        num <= NW'(lv_rd_q) + NW'(q) * NW'(q) - NW'(lv_rd_v) - NW'(apex_rd) * NW'(apex_rd);
        den <= DENW'({q - DW'(apex_rd), 1'b0});
      end
      OP_B_CMP: begin
        if (pop) begin
          h <= h - CW'(1);
        end else begin
          h   <= h + CW'(1);
          top <= h + CW'(1);
          q   <= q_last ? '0 : q + DW'(1);
        end
      end
      OP_E_INIT: begin
        h <= '0;
        q <= '0;
      end
      OP_E_CMP: begin
        if (adv) h <= h + CW'(1);
      end
      default: ;
    endcase
  end

  // Voxel distance field: one write port, one registered read port.
  always_comb begin
    field_we    = 1'b0;
    field_waddr = cur_addr;
    field_wdata = seed_val;
    case (cmd.op)
      OP_CLEAR: begin
        field_we    = 1'b1;
        field_waddr = clr;
        field_wdata = '0;
      end
      OP_SEED_WR: field_we = 1'b1;
      OP_E_WR: begin
        field_we    = 1'b1;
        field_wdata = eval_val;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (field_we) field_mem[field_waddr] <= field_wdata;
    if (cmd.op == OP_READ) field_rd <= field_mem[item_addr];
    else if (cmd.op == OP_LOAD_RD) field_rd <= field_mem[cur_addr];
  end

  // Free map.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_CLEAR) free_mem[clr] <= 1'b0;
    else if (cmd.op == OP_WRITE && item_inside) free_mem[item_addr] <= item_mark;
    if (cmd.op == OP_SEED_RD) free_rd <= free_mem[cur_addr];
  end

  // Line values: written in order, read at q and at an apex.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD_WR) lv_mem[q[CW-1:0]] <= field_rd;
    if (cmd.op == OP_B_RDF) lv_rd_q <= lv_mem[q[CW-1:0]];
    if (cmd.op == OP_B_RDF || cmd.op == OP_E_RDF) lv_rd_v <= lv_mem[apex_rd];
  end

  // Envelope apex store.
  assign apex_waddr = (cmd.op == OP_B_INIT) ? '0 : h + CW'(1);
  assign apex_wdata = (cmd.op == OP_B_INIT) ? '0 : q[CW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.op == OP_B_INIT || (cmd.op == OP_B_CMP && !pop)) begin
      apex_mem[apex_waddr] <= apex_wdata;
    end
    if (cmd.op == OP_B_RDA || cmd.op == OP_E_RDC) apex_rd <= apex_mem[h];
  end

  // Cut points as numerator and denominator.
  assign cut_raddr = (cmd.op == OP_E_RDC) ? h + CW'(1) : h;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_B_CMP && !pop) begin
      cnum_mem[h + CW'(1)] <= num;
      cden_mem[h + CW'(1)] <= den;
    end
    if (cmd.op == OP_B_RDA || cmd.op == OP_E_RDC) begin
      cnum_rd <= cnum_mem[cut_raddr];
      cden_rd <= cden_mem[cut_raddr];
    end
  end

  // Checks on the envelope walk and the result register.
  `VEDT_ASSERT_NOW(a_out_from_post, clk, rst, $rose(out_valid), $past(cmd.op == OP_POST), "result valid without a post")
  `VEDT_ASSERT_NEXT(a_post_sets_valid, clk, rst, cmd.op == OP_POST, out_valid, "post did not raise valid")
  `VEDT_ASSERT_NOW(a_eval_h_in_range, clk, rst, cmd.op == OP_E_CMP, h <= top, "envelope index past top")
  `VEDT_ASSERT_NOW(a_push_den_nonzero, clk, rst, cmd.op == OP_B_CMP && !pop, den != '0, "zero cut denominator")
  `VEDT_ASSERT_NOW(a_eval_q_in_line, clk, rst, cmd.op == OP_E_WR, q < n, "write past line end")

endmodule

/* tb/sv/testbench.sv */
// ============================================================================
// Voxel distance transform testbench
// Drives free-mark writes, transform runs and distance reads. A predictor
// kept in the bench computes each expected result, and every result transfer
// is checked against it in order, with random gaps and output stalls.
// ============================================================================
`timescale 1ns / 1ps

module testbench;
  import vedt_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int GRID = 32;
  localparam int CELLS = GRID * GRID * GRID;
  localparam longint CYCLE_LIMIT = 8000000;
  localparam int SETTLE = 16;

  typedef struct {
    logic            finished;
    logic            in_grid;
    logic [DIST_W-1:0] dist_val;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] kind = KIND_WRITE;
  logic [4:0] cell_x = '0, cell_y = '0, cell_z = '0;
  logic free_mark = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic finished, in_grid;
  logic [DIST_W-1:0] squared_distance;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = CFG_DIM_X;
  logic [5:0] cfg_data = '0;

  // Predicted block state.
  bit                free_cells [CELLS];
  logic [DIST_W-1:0] dist_cells [CELLS];
  logic [5:0]        dim_reg [3];
  longint line_in [GRID];
  longint line_res [GRID];
  int     apex [GRID];
  longint cut_num [GRID+1];
  longint cut_den [GRID+1];

  answer_t pending_answers[$];
  int mismatches = 0;
  int n_writes = 0, n_runs = 0, n_reads = 0, n_checked = 0;
  longint cycles = 0;
  int hold_off = 0;
  bit gaps_on = 1'b1;

  voxel_euclidean_distance_transform dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .cell_x(cell_x), .cell_y(cell_y), .cell_z(cell_z),
    .free_mark(free_mark),
    .out_valid(out_valid), .out_ready(out_ready),
    .finished(finished), .in_grid(in_grid), .squared_distance(squared_distance),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Give up on a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycles, pending_answers.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int used_dim(logic [5:0] d);
    if (d == 0) return 1;
    if (d > GRID) return GRID;
    return int'(d);
  endfunction

  function automatic int cell_index(int x, int y, int z);
    return (x * GRID + y) * GRID + z;
  endfunction

  // Exact 1-D lower envelope of parabolas over line_in[0..n-1].
  function automatic void envelope_line(int n);
    int h, q, v, top;
    longint num, den, dd, r;
    h = 0;
    apex[0] = 0;
    for (q = 1; q < n; q++) begin
      forever begin
        v = apex[h];
        num = (line_in[q] + q * q) - (line_in[v] + v * v);
        den = 2 * (q - v);
        if (h > 0 && num * cut_den[h] <= cut_num[h] * den) h--;
        else break;
      end
      h++;
      apex[h] = q;
      cut_num[h] = num;
      cut_den[h] = den;
    end
    top = h;
    h = 0;
    for (q = 0; q < n; q++) begin
      while (h < top && cut_num[h+1] < longint'(q) * cut_den[h+1]) h++;
      dd = q - apex[h];
      r = dd * dd + line_in[apex[h]];
      line_res[q] = (r > SEED_FAR) ? SEED_FAR : r;
    end
  endfunction

  // Seed the field, then sweep x, y and z.
  function automatic void transform_field();
    int d[3], c[3];
    int a, b, n, i, j, q, axis;
    bit rim;
    d[0] = used_dim(dim_reg[0]);
    d[1] = used_dim(dim_reg[1]);
    d[2] = used_dim(dim_reg[2]);
    for (int x = 0; x < d[0]; x++)
      for (int y = 0; y < d[1]; y++)
        for (int z = 0; z < d[2]; z++) begin
          rim = x == 0 || y == 0 || z == 0 ||
                x == d[0] - 1 || y == d[1] - 1 || z == d[2] - 1;
          dist_cells[cell_index(x, y, z)] =
            DIST_W'((free_cells[cell_index(x, y, z)] && !rim) ? SEED_FAR : 0);
        end
    for (axis = 0; axis < 3; axis++) begin
      a = (axis + 1) % 3;
      b = (axis + 2) % 3;
      n = d[axis];
      for (i = 0; i < d[a]; i++)
        for (j = 0; j < d[b]; j++) begin
          c[a] = i;
          c[b] = j;
          for (q = 0; q < n; q++) begin
            c[axis] = q;
            line_in[q] = dist_cells[cell_index(c[0], c[1], c[2])];
          end
          envelope_line(n);
          for (q = 0; q < n; q++) begin
            c[axis] = q;
            dist_cells[cell_index(c[0], c[1], c[2])] = DIST_W'(line_res[q]);
          end
        end
    end
  endfunction

  // Apply one accepted item and queue what it should answer.
  function automatic void predict_item(logic [1:0] k, int x, int y, int z, bit m);
    answer_t ans;
    bit in_dims;
    in_dims = x < used_dim(dim_reg[0]) && y < used_dim(dim_reg[1]) &&
              z < used_dim(dim_reg[2]);
    case (k)
      KIND_WRITE: begin
        if (in_dims) free_cells[cell_index(x, y, z)] = m;
        n_writes++;
      end
      KIND_RUN: begin
        transform_field();
        ans.finished = 1'b1;
        ans.in_grid = 1'b0;
        ans.dist_val = '0;
        pending_answers = {pending_answers, ans};
        n_runs++;
      end
      KIND_READ: begin
        ans.finished = 1'b0;
        ans.in_grid = in_dims;
        ans.dist_val = in_dims ? dist_cells[cell_index(x, y, z)] : '0;
        pending_answers = {pending_answers, ans};
        n_reads++;
      end
      default: ;
    endcase
  endfunction

  // Result checker.
  always @(posedge clk) begin
    answer_t ans;
    if (!rst && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result transfer at cycle %0d", cycles);
      end else begin
        ans = pending_answers.pop_front();
        n_checked++;
        if (finished !== ans.finished || in_grid !== ans.in_grid ||
            squared_distance !== ans.dist_val) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch at cycle %0d: expected fin=%0b grid=%0b dist=%0d, got fin=%0b grid=%0b dist=%0d",
                     cycles, ans.finished, ans.in_grid, ans.dist_val,
                     finished, in_grid, squared_distance);
        end
      end
    end
  end

  // Receiver stalls: a stall mode is drawn at random from three; a hold-off overrides all.
  initial begin
    int mode;
    mode = 0;
    forever begin
      @(negedge clk);
      if (cycles % 64 == 0) mode = $urandom_range(0, 2);
      if (hold_off > 0) begin
        out_ready = 1'b0;
        hold_off--;
      end else begin
        case (mode)
          0: out_ready = 1'b1;
          1: out_ready = ($urandom_range(0, 1) == 1);
          default: out_ready = ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Offer one item and hold it until the transfer; the next send may follow
  // directly so valid stays high across a burst.
  task automatic send_item(int k, int x, int y, int z, int m);
    in_valid = 1'b1;
    kind = 2'(k);
    cell_x = 5'(x);
    cell_y = 5'(y);
    cell_z = 5'(z);
    free_mark = 1'(m);
    do @(posedge clk); while (!in_ready);
    predict_item(kind, int'(cell_x), int'(cell_y), int'(cell_z), free_mark);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic wait_results();
    in_valid = 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Register writes happen only once the block has drained.
  task automatic set_dims(int dx, int dy, int dz);
    logic [5:0] vals[3];
    logic [1:0] idx[3];
    vals = '{6'(dx), 6'(dy), 6'(dz)};
    idx = '{CFG_DIM_X, CFG_DIM_Y, CFG_DIM_Z};
    wait_results();
    for (int i = 0; i < 3; i++) begin
      cfg_valid = 1'b1;
      cfg_index = idx[i];
      cfg_data = vals[i];
      do @(posedge clk); while (!cfg_ready);
      dim_reg[i] = vals[i];
      @(negedge clk);
    end
    cfg_valid = 1'b0;
  endtask

  task automatic read_cell(int x, int y, int z);
    send_item(KIND_READ, x, y, z, 0);
  endtask

  // Reads before any run answer zero; the unused kind is inert, and a corner cell is marked free.
  task automatic test_reset_state();
    read_cell(0, 0, 0);
    read_cell(31, 31, 31);
    read_cell(17, 5, 30);
    send_item(KIND_UNUSED, 3, 4, 5, 1);
    send_item(KIND_WRITE, 31, 0, 31, 1);
  endtask

  // Full 32-cube with a few free cells: extremes of the coordinate fields.
  task automatic test_full_grid();
    send_item(KIND_WRITE, 16, 16, 16, 1);
    send_item(KIND_WRITE, 1, 1, 1, 1);
    send_item(KIND_WRITE, 30, 30, 30, 1);
    send_item(KIND_WRITE, 1, 1, 1, 0);
    send_item(KIND_RUN, 0, 0, 0, 0);
    read_cell(16, 16, 16);
    read_cell(30, 30, 30);
    read_cell(1, 1, 1);
    read_cell(31, 31, 31);
  endtask

  // A free block on a small grid, then outside reads and out-of-range dims.
  task automatic test_small_grid();
    set_dims(7, 7, 7);
    for (int x = 1; x < 6; x++)
      for (int y = 1; y < 6; y++)
        send_item(KIND_WRITE, x, y, 3, 1);
    send_item(KIND_WRITE, 8, 1, 1, 1);
    send_item(KIND_RUN, 0, 0, 0, 0);
    read_cell(3, 3, 3);
    read_cell(2, 4, 3);
    read_cell(7, 1, 1);
    read_cell(1, 1, 31);
    // Zero acts as one and values above the grid act as the grid size.
    set_dims(0, 63, 1);
    send_item(KIND_RUN, 0, 0, 0, 0);
    read_cell(0, 31, 0);
    read_cell(1, 0, 0);
    // Shrinking the grid leaves old values at cells past the new edge.
    set_dims(3, 3, 3);
    send_item(KIND_RUN, 0, 0, 0, 0);
    set_dims(32, 32, 32);
    read_cell(2, 2, 3);
    read_cell(3, 3, 3);
  endtask

  // Long receiver hold while reads pile up; then a drained pause.
  task automatic test_backpressure();
    set_dims(5, 6, 4);
    send_item(KIND_RUN, 0, 0, 0, 0);
    hold_off = 300;
    gaps_on = 1'b0;
    for (int i = 0; i < 6; i++)
      read_cell($urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 5));
    gaps_on = 1'b1;
    wait_results();
  endtask

  // Random sequences: set dims, mark free cells among stray items, run, read back.
  task automatic test_random();
    int dx, dy, dz, nw;
    for (int s = 0; s < 5; s++) begin
      dx = $urandom_range(2, 9);
      dy = $urandom_range(2, 9);
      dz = $urandom_range(2, 9);
      case ($urandom_range(0, 5))
        0: dx = 32;
        1: dy = $urandom_range(0, 1);
        2: dz = $urandom_range(33, 63);
        default: ;
      endcase
      set_dims(dx, dy, dz);
      dx = used_dim(6'(dx));
      dy = used_dim(6'(dy));
      dz = used_dim(6'(dz));
      nw = $urandom_range(3, 8);
      for (int i = 0; i < nw; i++) begin
        if ($urandom_range(0, 4) == 0)
          send_item($urandom_range(0, 3), $urandom, $urandom, $urandom, $urandom);
        else
          send_item(KIND_WRITE, $urandom_range(0, dx - 1), $urandom_range(0, dy - 1),
                    $urandom_range(0, dz - 1), $urandom_range(0, 5) != 0);
      end
      send_item(KIND_RUN, $urandom, $urandom, $urandom, $urandom);
      for (int i = 0; i < 4; i++) begin
        if ($urandom_range(0, 3) == 0)
          send_item(KIND_READ, $urandom, $urandom, $urandom, $urandom);
        else
          send_item(KIND_READ, $urandom_range(0, dx - 1), $urandom_range(0, dy - 1),
                    $urandom_range(0, dz - 1), $urandom);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < CELLS; i++) begin
      free_cells[i] = 1'b0;
      dist_cells[i] = '0;
    end
    for (int i = 0; i < 3; i++) dim_reg[i] = DIM_RESET;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_full_grid();
    test_small_grid();
    test_backpressure();
    test_random();
    wait_results();

    $display("Covered %0d writes, %0d transform runs and %0d reads; %0d results checked.",
             n_writes, n_runs, n_reads, n_checked);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
